### hdl/size_class_frame_allocator_core_defines.svh
// Assertion macros shared by the allocator checker.
`ifndef SIZE_CLASS_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define SIZE_CLASS_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SCFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/scfa_pkg.sv
// Shared types, pool layout constants and helper functions of the frame allocator.
`default_nettype none
package scfa_pkg;

  localparam int FRAMES_SMALL  = 32;
  localparam int FRAMES_MEDIUM = 16;
  localparam int FRAMES_LARGE  = 16;
  localparam int POOL_MAX      = 64;
  localparam int CLASS_N       = 3;

  localparam int FRAME_W = $clog2(POOL_MAX);
  localparam int LINK_W  = FRAME_W + 1;
  localparam int BASE_W  = 32;
  localparam int BYTES_W = 24;
  localparam int PROD_W  = LINK_W + BYTES_W;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_MAX);

  // Cut class counts so the pool never exceeds its maximum.
  localparam int CNT0 = (FRAMES_SMALL < POOL_MAX) ? FRAMES_SMALL : POOL_MAX;
  localparam int CNT1 = (FRAMES_MEDIUM < POOL_MAX - CNT0) ? FRAMES_MEDIUM : POOL_MAX - CNT0;
  localparam int CNT2 = (FRAMES_LARGE < POOL_MAX - CNT0 - CNT1) ? FRAMES_LARGE
                        : POOL_MAX - CNT0 - CNT1;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [1:0]        cls_t;

  localparam cls_t CLASS_NONE = 2'd3;

  localparam link_t CLS_FIRST [CLASS_N] = '{link_t'(0), link_t'(CNT0), link_t'(CNT0 + CNT1)};
  localparam link_t CLS_COUNT [CLASS_N] = '{link_t'(CNT0), link_t'(CNT1), link_t'(CNT2)};

  localparam logic [BYTES_W-1:0] BYTES_SMALL_RST  = 24'd4096;
  localparam logic [BYTES_W-1:0] BYTES_MEDIUM_RST = 24'd16384;
  localparam logic [BYTES_W-1:0] BYTES_LARGE_RST  = 24'd65536;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_INACTIVE  = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RECLAIM = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    CFG_BASE   = 2'd0,
    CFG_SMALL  = 2'd1,
    CFG_MEDIUM = 2'd2,
    CFG_LARGE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic acc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic alloc_ok;
    logic last_term;
  } dp_stat_t;

  // Class that owns frame f, CLASS_NONE past the end of the pool.
  function automatic cls_t class_of(input logic [FRAME_W-1:0] f);
    logic [LINK_W:0] fx;
    cls_t            c;
    fx = {2'b00, f};
    c  = CLASS_NONE;
    for (int k = CLASS_N - 1; k >= 0; k--) begin
      if (fx >= {1'b0, CLS_FIRST[k]} &&
          fx < ({1'b0, CLS_FIRST[k]} + {1'b0, CLS_COUNT[k]})) begin
        c = cls_t'(k);
      end
    end
    return c;
  endfunction

  // Link of frame f right after reset: next frame of its class or end.
  function automatic link_t link_reset(input logic [FRAME_W-1:0] f);
    cls_t            c;
    logic [LINK_W:0] nxt;
    link_t           l;
    c   = class_of(f);
    nxt = {2'b00, f} + (LINK_W + 1)'(1);
    l   = LINK_END;
    if (c != CLASS_NONE) begin
      if (nxt < ({1'b0, CLS_FIRST[c]} + {1'b0, CLS_COUNT[c]})) begin
        l = nxt[LINK_W-1:0];
      end
    end
    return l;
  endfunction

endpackage
`default_nettype wire

### hdl/size_class_frame_allocator_core.sv
// Top level of the size-class frame allocator: controller plus datapath.
//
//   channel   ports                                          handshake
//   request   start, busy, req_type, size_class, frame_id    start && !busy
//   result    done, status, granted_frame, stack_address     done, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
//
// A reclaim or a failed allocate goes from EXEC straight to DONE;
// an allocate runs MUL/ACC rounds before DONE, one per stack area term, on
// the shared multiplier: one for each earlier class and one for its own.
// busy drops the cycle after done, so one request runs at a time.
// rst is synchronous: it restores every class list to ascending order.
// Results cannot be held off; config writes are always ready.
`default_nettype none
module size_class_frame_allocator_core
  import scfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic [1:0]         size_class,
  input  wire logic [FRAME_W-1:0] frame_id,
  output logic                    done,
  output logic [1:0]              status,
  output logic [FRAME_W-1:0]      granted_frame,
  output logic [BASE_W-1:0]       stack_address,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [BASE_W-1:0]  cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  scfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  scfa_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .size_class    (size_class),
    .frame_id      (frame_id),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .granted_frame (granted_frame),
    .stack_address (stack_address)
  );

endmodule
`default_nettype wire

### hdl/scfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/scfa_ctrl.sv
// Controller state machine sequencing one request through the datapath.
`default_nettype none
module scfa_ctrl
  import scfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd,
  output logic           busy,
  output logic           done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = stat.alloc_ok ? S_MUL : S_DONE;
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = stat.last_term ? S_DONE : S_MUL;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_ACC:  cmd.acc  = 1'b1;
      S_DONE: done     = 1'b1;
      default: busy    = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

### hdl/scfa_datapath.sv
// Datapath: free lists, active flags, configuration and address accumulator.
`default_nettype none
module scfa_datapath
  import scfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  input  wire logic               req_type,
  input  wire logic [1:0]         size_class,
  input  wire logic [FRAME_W-1:0] frame_id,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [BASE_W-1:0]  cfg_data,
  output logic [1:0]              status,
  output logic [FRAME_W-1:0]      granted_frame,
  output logic [BASE_W-1:0]       stack_address
);

  // Configuration registers
  logic [BASE_W-1:0]  base;
  logic [BYTES_W-1:0] bytes [CLASS_N];

  // Allocator state
  link_t               head [CLASS_N];
  logic [POOL_MAX-1:0] active;
  logic [POOL_MAX-1:0] link_valid;

  // Captured request
  logic               req_q;
  cls_t               cls_q;
  logic [FRAME_W-1:0] fid_q;
  logic [FRAME_W-1:0] rd_addr_q;
  logic               rd_valid_q;

  // Address accumulation
  cls_t              term_k;
  logic [PROD_W-1:0] prod;
  logic [FRAME_W-1:0] frame_q;

  logic [FRAME_W-1:0] rd_addr_next;
  cls_t               in_sel;
  cls_t               cls_sel;
  link_t              head_cur;
  link_t              ram_q;
  link_t              link_cur;
  logic               alloc_ok;
  cls_t               rc_cls;
  cls_t               rc_sel;
  logic               rc_ok;
  status_t            status_next;
  logic [FRAME_W-1:0] idx;
  link_t              mul_a;
  logic [BYTES_W-1:0] mul_b;

  // Read the head frame's link as the request is taken.
  assign in_sel       = (size_class == CLASS_NONE) ? cls_t'(0) : cls_t'(size_class);
  assign rd_addr_next = head[in_sel][FRAME_W-1:0];

  scfa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_MAX)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.exec && rc_ok),
    .waddr (fid_q),
    .wdata (head[rc_sel]),
    .raddr (rd_addr_next),
    .rdata (ram_q)
  );

  assign cls_sel  = (cls_q == CLASS_NONE) ? cls_t'(0) : cls_q;
  assign head_cur = head[cls_sel];
  assign link_cur = rd_valid_q ? ram_q : link_reset(rd_addr_q);
  assign alloc_ok = (req_q == REQ_ALLOC) && (cls_q != CLASS_NONE) && !head_cur[LINK_W-1];

  assign rc_cls = class_of(fid_q);
  assign rc_sel = (rc_cls == CLASS_NONE) ? cls_t'(0) : rc_cls;
  assign rc_ok  = (req_q == REQ_RECLAIM) && (rc_cls != CLASS_NONE) && active[fid_q];

  always_comb begin
    if (req_q == REQ_ALLOC) begin
      if (cls_q == CLASS_NONE) begin
        status_next = ST_BAD_CLASS;
      end else if (head_cur[LINK_W-1]) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_OK;
      end
    end else begin
      status_next = rc_ok ? ST_OK : ST_INACTIVE;
    end
  end

  // Earlier classes add their whole stack area, the own class adds idx stacks.
  assign idx = frame_q - CLS_FIRST[cls_sel][FRAME_W-1:0];
  always_comb begin
    if (term_k < cls_sel) begin
      mul_a = CLS_COUNT[term_k];
      mul_b = bytes[term_k];
    end else begin
      mul_a = {1'b0, idx};
      mul_b = bytes[cls_sel];
    end
  end

  assign stat.alloc_ok  = alloc_ok;
  assign stat.last_term = (term_k == cls_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      bytes[0]   <= BYTES_SMALL_RST;
      bytes[1]   <= BYTES_MEDIUM_RST;
      bytes[2]   <= BYTES_LARGE_RST;
      active     <= '0;
      link_valid <= '0;
      for (int k = 0; k < CLASS_N; k++) begin
        head[k] <= (CLS_COUNT[k] != '0) ? CLS_FIRST[k] : LINK_END;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BASE:   base     <= cfg_data;
          CFG_SMALL:  bytes[0] <= cfg_data[BYTES_W-1:0];
          CFG_MEDIUM: bytes[1] <= cfg_data[BYTES_W-1:0];
          CFG_LARGE:  bytes[2] <= cfg_data[BYTES_W-1:0];
        endcase
      end
      if (cmd.exec) begin
        if (alloc_ok) begin
          active[rd_addr_q] <= 1'b1;
          head[cls_sel]     <= link_cur;
        end else if (rc_ok) begin
          active[fid_q]     <= 1'b0;
          link_valid[fid_q] <= 1'b1;
          head[rc_sel]      <= {1'b0, fid_q};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q      <= req_type;
      cls_q      <= size_class;
      fid_q      <= frame_id;
      rd_addr_q  <= rd_addr_next;
      rd_valid_q <= link_valid[rd_addr_next];
    end
    if (cmd.exec) begin
      status        <= status_next;
      frame_q       <= rd_addr_q;
      granted_frame <= alloc_ok ? rd_addr_q : '0;
      stack_address <= alloc_ok ? base : '0;
      term_k        <= '0;
    end
    if (cmd.mul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc) begin
      stack_address <= stack_address + BASE_W'(prod);
      term_k        <= term_k + cls_t'(1);
    end
  end

endmodule
`default_nettype wire

### hdl/scfa_checker.sv
// Port-level checker for the frame allocator and its bind to the top level.
`default_nettype none
`include "size_class_frame_allocator_core_defines.svh"
module scfa_checker
  import scfa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [1:0]         status,
  input wire logic [FRAME_W-1:0] granted_frame,
  input wire logic [BASE_W-1:0]  stack_address
);

  `SCFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted transaction not busy")
  `SCFA_ASSERT_SAME(a_done_busy, done, busy, "result strobe while idle")
  `SCFA_ASSERT_NEXT(a_done_once, done, !done && !busy, "result strobe not single or busy stuck")
  `SCFA_ASSERT_SAME(a_fail_zero, done && (status != 2'(ST_OK)),
                    (granted_frame == '0) && (stack_address == '0),
                    "failed transaction carries nonzero fields")

endmodule

bind size_class_frame_allocator_core scfa_checker u_scfa_checker (.*);
`default_nettype wire

### test/size_class_frame_allocator_core_tb.sv
// Self-checking testbench for the size-class frame allocator core.
`timescale 1ns / 1ps

module size_class_frame_allocator_core_tb;
  import scfa_pkg::*;

  typedef struct {
    req_t               kind;
    logic [1:0]         cls;
    logic [FRAME_W-1:0] fid;
  } request_t;

  typedef struct {
    req_t               kind;
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic [BASE_W-1:0]  addr;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               req_type = 1'b0;
  logic [1:0]         size_class = 2'd0;
  logic [FRAME_W-1:0] frame_id = '0;
  logic               cfg_valid = 1'b0;
  cfg_idx_t           cfg_index = CFG_BASE;
  logic [BASE_W-1:0]  cfg_data = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic [FRAME_W-1:0] granted_frame;
  logic [BASE_W-1:0]  stack_address;
  logic               cfg_ready;

  size_class_frame_allocator_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .size_class   (size_class),
    .frame_id     (frame_id),
    .done         (done),
    .status       (status),
    .granted_frame(granted_frame),
    .stack_address(stack_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the allocator: free lists, ownership and stack layout.
  link_t              next_link [POOL_MAX];
  link_t              class_head [CLASS_N];
  logic               frame_active [POOL_MAX];
  logic [BASE_W-1:0]  base_sh;
  logic [BYTES_W-1:0] area_bytes [CLASS_N];

  request_t request_q [$];
  grant_t   owed_grants [$];

  int fail_count = 0;
  int accepted_n = 0;
  int n_granted = 0;
  int n_empty = 0;
  int n_inactive = 0;
  int n_bad = 0;
  int n_freed = 0;
  int n_phases = 0;

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    link_t  f;
    int     c;
    g.kind   = r.kind;
    g.status = ST_OK;
    g.frame  = '0;
    g.addr   = '0;
    if (r.kind == REQ_ALLOC) begin
      if (r.cls == CLASS_NONE) begin
        g.status = ST_BAD_CLASS;
      end else if (class_head[r.cls] >= LINK_END) begin
        g.status = ST_EMPTY;
      end else begin
        f = class_head[r.cls];
        frame_active[f[FRAME_W-1:0]] = 1'b1;
        class_head[r.cls] = next_link[f[FRAME_W-1:0]];
        g.frame = f[FRAME_W-1:0];
        g.addr  = base_sh;
        for (int k = 0; k < CLASS_N; k++) begin
          if (k < int'(r.cls)) begin
            g.addr = g.addr + 32'(CLS_COUNT[k]) * 32'(area_bytes[k]);
          end
        end
        g.addr = g.addr + (32'(f) - 32'(CLS_FIRST[r.cls])) * 32'(area_bytes[r.cls]);
      end
    end else begin
      c = CLASS_N;
      for (int k = 0; k < CLASS_N; k++) begin
        if (int'(r.fid) >= int'(CLS_FIRST[k]) &&
            int'(r.fid) < int'(CLS_FIRST[k]) + int'(CLS_COUNT[k])) begin
          c = k;
        end
      end
      if (c == CLASS_N || !frame_active[r.fid]) begin
        g.status = ST_INACTIVE;
      end else begin
        // Push back onto the frame's own class, whatever size_class says.
        frame_active[r.fid] = 1'b0;
        next_link[r.fid]    = class_head[c];
        class_head[c]       = link_t'(r.fid);
      end
    end
    return g;
  endfunction

  // Request driver: bursts of back-to-back requests separated by idle gaps.
  int   gap_left = 0;
  int   burst_left = 1;
  logic start_nxt;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      base_sh = '0;
      area_bytes[0] = BYTES_SMALL_RST;
      area_bytes[1] = BYTES_MEDIUM_RST;
      area_bytes[2] = BYTES_LARGE_RST;
      for (int i = 0; i < POOL_MAX; i++) begin
        next_link[i]    = LINK_END;
        frame_active[i] = 1'b0;
      end
      for (int k = 0; k < CLASS_N; k++) begin
        class_head[k] = (CLS_COUNT[k] != 0) ? CLS_FIRST[k] : LINK_END;
        for (int j = 0; j < int'(CLS_COUNT[k]); j++) begin
          next_link[int'(CLS_FIRST[k]) + j] = (j + 1 < int'(CLS_COUNT[k]))
              ? link_t'(int'(CLS_FIRST[k]) + j + 1) : LINK_END;
        end
      end
    end else begin
      start_nxt = start;
      if (start && !busy) begin
        owed_grants.push_back(serve_request(request_q[0]));
        void'(request_q.pop_front());
        accepted_n++;
        start_nxt = 1'b0;
      end
      if (!start_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          req_type   <= request_q[0].kind;
          size_class <= request_q[0].cls;
          frame_id   <= request_q[0].fid;
          start_nxt  = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      start <= start_nxt;
    end
  end

  // Result monitor: every done strobe carries one transaction.
  grant_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_grants.size() == 0) begin
        $error("unexpected result: status %0d frame %0d addr %h",
               status, granted_frame, stack_address);
        fail_count++;
      end else begin
        want = owed_grants.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (granted_frame !== want.frame) begin
          $error("granted_frame: expected %0d, got %0d", want.frame, granted_frame);
          fail_count++;
        end
        if (stack_address !== want.addr) begin
          $error("stack_address: expected %h, got %h", want.addr, stack_address);
          fail_count++;
        end
        case (want.status)
          ST_OK:        if (want.kind == REQ_RECLAIM) n_freed++;
                        else n_granted++;
          ST_EMPTY:     n_empty++;
          ST_INACTIVE:  n_inactive++;
          ST_BAD_CLASS: n_bad++;
          default:      ;
        endcase
      end
    end
  end

  task automatic push_req(req_t kind, logic [1:0] cls, logic [FRAME_W-1:0] fid);
    request_t r;
    r.kind = kind;
    r.cls  = cls;
    r.fid  = fid;
    request_q.push_back(r);
  endtask

  // Hold until every request is out, every result back and the core idle.
  task automatic settle();
    while (request_q.size() > 0 || owed_grants.size() > 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [BASE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE:   base_sh = data;
      CFG_SMALL:  area_bytes[0] = data[BYTES_W-1:0];
      CFG_MEDIUM: area_bytes[1] = data[BYTES_W-1:0];
      CFG_LARGE:  area_bytes[2] = data[BYTES_W-1:0];
      default:    ;
    endcase
  endtask

  initial begin
    int       alloc_pct [6];
    int       held [$];
    request_t r;

    alloc_pct = '{70, 45, 85, 55, 65, 30};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: each class, bad class, inactive and double reclaim, LIFO reuse,
    // reclaim ignoring size_class, then drain the large class past empty.
    push_req(REQ_ALLOC, 2'd0, 6'd63);
    push_req(REQ_ALLOC, 2'd1, 6'd0);
    push_req(REQ_ALLOC, 2'd2, 6'd0);
    push_req(REQ_ALLOC, CLASS_NONE, 6'd0);
    push_req(REQ_RECLAIM, 2'd0, 6'd1);
    push_req(REQ_RECLAIM, 2'd3, 6'd63);
    push_req(REQ_RECLAIM, 2'd0, 6'd32);
    push_req(REQ_RECLAIM, 2'd1, 6'd32);
    push_req(REQ_ALLOC, 2'd1, 6'd0);
    push_req(REQ_RECLAIM, 2'd3, 6'd0);
    for (int i = 0; i < 16; i++) push_req(REQ_ALLOC, 2'd2, 6'($urandom));
    push_req(REQ_RECLAIM, 2'd2, 6'd63);
    push_req(REQ_ALLOC, 2'd2, 6'd0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_BASE, 32'hFFFF_FFFF);
          write_reg(CFG_SMALL, 32'hFFFF_FFFF);
          write_reg(CFG_MEDIUM, 32'hFFFF_FFFF);
          write_reg(CFG_LARGE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_BASE, 32'h0);
          write_reg(CFG_SMALL, 32'hFF00_0000);
          write_reg(CFG_MEDIUM, 32'h0);
          write_reg(CFG_LARGE, 32'h0);
        end
        default: begin
          write_reg(CFG_BASE, $urandom);
          write_reg(CFG_SMALL, $urandom);
          write_reg(CFG_MEDIUM, $urandom);
          write_reg(CFG_LARGE, $urandom);
        end
      endcase
      n_phases++;

      for (int n = 0; n < 285; n++) begin
        // Keep the queue short so reclaims can target frames held right now.
        while (request_q.size() > 1) @(posedge clk);
        r.kind = ($urandom_range(0, 99) < alloc_pct[p]) ? REQ_ALLOC : REQ_RECLAIM;
        r.cls  = ($urandom_range(0, 15) == 0) ? CLASS_NONE : 2'($urandom_range(0, 2));
        r.fid  = 6'($urandom);
        if (r.kind == REQ_RECLAIM && $urandom_range(0, 9) < 8) begin
          held.delete();
          for (int i = 0; i < POOL_MAX; i++) if (frame_active[i]) held.push_back(i);
          if (held.size() > 0) r.fid = 6'(held[$urandom_range(0, held.size() - 1)]);
        end
        request_q.push_back(r);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("%0d requests over %0d register settings: %0d grants, %0d frees,",
             accepted_n, n_phases + 1, n_granted, n_freed);
    $display("%0d empty-class, %0d inactive-reclaim and %0d bad-class answers",
             n_empty, n_inactive, n_bad);
    if (fail_count == 0) begin
      $display("size_class_frame_allocator_core_tb OK");
    end else begin
      $display("size_class_frame_allocator_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still owed", owed_grants.size());
    $display("size_class_frame_allocator_core_tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/scfa_pkg.sv
hdl/scfa_ram.sv
hdl/scfa_ctrl.sv
hdl/scfa_datapath.sv
hdl/size_class_frame_allocator_core.sv
hdl/scfa_checker.sv
test/size_class_frame_allocator_core_tb.sv
